/* src/hdls_pkg.sv */
// Package for the heat diffusion line step block: request and result types,
// command and configuration register codes, and sizing constants.
// No dependencies.
`timescale 1ns / 1ps

package hdls_pkg;

  // Number of cells on the line, between 3 and 64.
  localparam int CELLS = 64;
  localparam int IDX_W = 6;
  // The step sequencer counts up to CELLS + 2.
  localparam int T_W   = $clog2(CELLS + 3);

  localparam int TEMP_W  = 32;
  localparam int DIFF_W  = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_DIFFUSION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_GAIN = 1'b1;

  typedef struct packed {
    logic                     cmd;
    logic [IDX_W-1:0]         cell_index;
    logic signed [TEMP_W-1:0] cell_value;
  } in_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]         out_index;
    logic signed [TEMP_W-1:0] temperature;
    logic                     last_cell;
  } out_res_t;

endpackage

/* src/heat_diffusion_line_step.sv */
// Top level of the heat diffusion line step: cell store, step sequencer and
// the shared multiply, round and saturate pipeline. Uses hdls_pkg.
// Timing: a write request is taken without raising busy. A step request raises
// busy; its results then follow one per cycle, paced by the single read port
// of the cell store walking one cell per cycle.
// Reset (synchronous, active low) zeroes both registers and all valid bits.
`timescale 1ns / 1ps

module heat_diffusion_line_step (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  hdls_pkg::in_req_t                  in_req,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [hdls_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hdls_pkg::TEMP_W-1:0]        cfg_data,
  output logic                               out_valid,
  output hdls_pkg::out_res_t                 out_res
);
  import hdls_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  localparam logic [T_W-1:0]   T_LAST  = T_W'(CELLS + 2);
  localparam logic [IDX_W:0]   CELLS_X = (IDX_W + 1)'(CELLS);
  localparam logic [IDX_W-1:0] J_LAST  = IDX_W'(CELLS - 1);

  state_t state_r, state_nxt;
  logic [T_W-1:0] t_r, t_nxt;

  logic [DIFF_W-1:0]        diff_num_r;
  logic signed [TEMP_W-1:0] edge_gain_r;

  // Cell store with one write and one registered read port.
  logic signed [TEMP_W-1:0] mem [CELLS];
  logic [CELLS-1:0]         valid_r;
  logic signed [TEMP_W-1:0] mem_q_r;
  logic                     rd_ok_r;
  logic [IDX_W-1:0]         rd_addr;
  logic                     mem_we;
  logic [IDX_W-1:0]         mem_wa;
  logic signed [TEMP_W-1:0] mem_wd;
  logic signed [TEMP_W-1:0] q;

  // Sliding window of old values.
  logic signed [TEMP_W-1:0] wa_r, wb_r;

  // Stage A: neighbour difference.
  logic                     fire;
  logic [IDX_W-1:0]         j_fire;
  logic signed [TEMP_W-1:0] left_v, right_v;
  logic signed [33:0]       nsum, ncen;
  logic signed [34:0]       d_nxt, d_r;
  logic signed [TEMP_W-1:0] cen_a_r;
  logic [IDX_W-1:0]         j_a_r;
  logic                     va_r;

  // Stage M: product with the diffusion number.
  logic signed [16:0]       r_s;
  logic signed [51:0]       prod_r;
  logic signed [TEMP_W-1:0] cen_m_r;
  logic [IDX_W-1:0]         j_m_r;
  logic                     vm_r;

  // Stage B: accumulate and round.
  logic signed [51:0]       acc;
  logic signed [35:0]       v_r;
  logic [IDX_W-1:0]         j_b_r;
  logic                     vb_r;

  // Stage C: edge deposit and saturation.
  logic signed [36:0]       s_sum;
  logic signed [TEMP_W-1:0] s_sat;
  logic                     c_last;

  logic write_acc, step_acc;

  assign busy      = (state_r != ST_IDLE);
  // Register writes are held off while a step is in progress.
  assign cfg_ready = !busy;
  assign write_acc = start && !busy && (in_req.cmd == CMD_WRITE);
  assign step_acc  = start && !busy && (in_req.cmd == CMD_STEP);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_num_r  <= '0;
      edge_gain_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DIFFUSION: diff_num_r  <= cfg_data[DIFF_W-1:0];
        CFG_EDGE_GAIN: edge_gain_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    t_nxt     = t_r;
    unique case (state_r)
      ST_IDLE: begin
        t_nxt = '0;
        if (step_acc) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (t_r != T_LAST) begin
          t_nxt = t_r + 1'b1;
        end
        if (vb_r && c_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      t_r     <= '0;
    end else begin
      state_r <= state_nxt;
      t_r     <= t_nxt;
    end
  end

  // Store access. A cell never written since reset reads as zero.
  assign rd_addr = t_r[IDX_W-1:0];
  assign q       = rd_ok_r ? mem_q_r : '0;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = in_req.cell_index;
    mem_wd = in_req.cell_value;
    if (vb_r) begin
      mem_we = 1'b1;
      mem_wa = j_b_r;
      mem_wd = s_sat;
    end else if (write_acc && ({1'b0, in_req.cell_index} < CELLS_X)) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      if (mem_we) begin
        valid_r[mem_wa] <= 1'b1;
      end
      rd_ok_r <= valid_r[rd_addr];
    end
  end

  // The window is shifted every cycle; cell j fires at t = j + 2, when the old
  // values of cells j-1 and j sit in the window and cell j+1 is on the read port.
  always_ff @(posedge clk) begin
    wa_r <= wb_r;
    wb_r <= q;
  end

  assign fire   = (state_r == ST_RUN) && (t_r >= T_W'(2)) && (t_r != T_LAST);
  assign j_fire = IDX_W'(t_r - T_W'(2));

  always_comb begin
    left_v  = (j_fire != '0)     ? wa_r : '0;
    right_v = (j_fire != J_LAST) ? q    : '0;
    nsum    = {{2{left_v[TEMP_W-1]}}, left_v} + {{2{right_v[TEMP_W-1]}}, right_v};
    if ((j_fire == '0) || (j_fire == J_LAST)) begin
      ncen = {{2{wb_r[TEMP_W-1]}}, wb_r};
    end else begin
      ncen = {wb_r[TEMP_W-1], wb_r, 1'b0};
    end
    d_nxt = {nsum[33], nsum} - {ncen[33], ncen};
  end

  assign r_s = {1'b0, diff_num_r};
  assign acc = {{4{cen_m_r[TEMP_W-1]}}, cen_m_r, 16'b0} + prod_r + 52'sd32768;

  assign c_last = (j_b_r == J_LAST);

  always_comb begin
    s_sum = {v_r[35], v_r};
    if (c_last) begin
      s_sum = s_sum + {{5{edge_gain_r[TEMP_W-1]}}, edge_gain_r};
    end
    if (s_sum[36:31] == 6'b000000 || s_sum[36:31] == 6'b111111) begin
      s_sat = s_sum[TEMP_W-1:0];
    end else if (s_sum[36]) begin
      s_sat = {1'b1, {(TEMP_W-1){1'b0}}};
    end else begin
      s_sat = {1'b0, {(TEMP_W-1){1'b1}}};
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    d_r     <= d_nxt;
    cen_a_r <= wb_r;
    j_a_r   <= j_fire;
    prod_r  <= r_s * d_r;
    cen_m_r <= cen_a_r;
    j_m_r   <= j_a_r;
    v_r     <= acc[51:16];
    j_b_r   <= j_m_r;
    out_res.out_index   <= j_b_r;
    out_res.temperature <= s_sat;
    out_res.last_cell   <= c_last;
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r      <= 1'b0;
      vm_r      <= 1'b0;
      vb_r      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      va_r      <= fire;
      vm_r      <= va_r;
      vb_r      <= vm_r;
      out_valid <= vb_r;
    end
  end

  // A result that is not the last one is always followed by the next cell.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_res.last_cell |=>
      out_valid && (out_res.out_index == $past(out_res.out_index) + 1'b1))
    else $error("step results are not consecutive");

  // Results appear only while a step is in progress.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy || $past(busy))
    else $error("result outside a step");

  // Busy rises only after an accepted step request.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start) && $past(in_req.cmd == CMD_STEP))
    else $error("busy raised without a step request");

  // A store write from the pipeline never coincides with a write request.
  assert property (@(posedge clk) disable iff (!rst_n)
    vb_r |-> !write_acc)
    else $error("store write collision");

endmodule
